@@ sv/ata_pkg.sv @@
// ----------------------------------------------------------------------------
// ata_pkg
// Shared constants for the accelerometer tilt angle unit: register width and
// reset value, fixed-point scaling and the CORDIC arctangent step table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ata_pkg;

  localparam int CFG_WIDTH = 12;
  localparam logic [CFG_WIDTH-1:0] OFFSET_RESET = 12'd1621;

  // deltas and roots carry this many fraction bits
  localparam int FRAC_BITS = 8;

  localparam int ACC_WIDTH = 32;
  localparam logic [ACC_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam int ATAN_LEN = 24;
  localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

@@ sv/ata_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// ata_sqrt_cell
// One digit cell of the square root chain: brings down two radicand bits,
// tries one root bit and hands remainder, root and passenger to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_sqrt_cell #(
  parameter int RB   = 21,
  parameter int PAIR = 20,
  parameter int PW   = 13
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2*RB-1:0]      rad_in,
  input  logic [RB+2:0]        rem_in,
  input  logic [RB-1:0]        root_in,
  input  logic signed [PW-1:0] pass_in,
  output logic [2*RB-1:0]      rad_out,
  output logic [RB+2:0]        rem_out,
  output logic [RB-1:0]        root_out,
  output logic signed [PW-1:0] pass_out
);

  logic [RB+2:0] rem_sh;
  logic [RB+2:0] trial;
  logic          fits;
  logic [RB+2:0] rem_next;
  logic [RB-1:0] root_next;

  always_comb begin
    rem_sh    = {rem_in[RB:0], rad_in[2*PAIR+1 -: 2]};
    trial     = {1'b0, root_in, 2'b01};
    fits      = (rem_sh >= trial);
    rem_next  = fits ? (rem_sh - trial) : rem_sh;
    root_next = {root_in[RB-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in;
      rem_out  <= rem_next;
      root_out <= root_next;
      pass_out <= pass_in;
    end
  end

endmodule

@@ sv/ata_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// ata_cordic_cell
// One vectoring CORDIC iteration: rotates toward the x axis by the fixed step
// angle of this cell and accumulates the angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_cordic_cell #(
  parameter int W    = 24,
  parameter int STEP = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [W-1:0]            x_in,
  input  logic signed [W-1:0]            y_in,
  input  logic [ata_pkg::ACC_WIDTH-1:0]  acc_in,
  input  logic                           zero_in,
  output logic signed [W-1:0]            x_out,
  output logic signed [W-1:0]            y_out,
  output logic [ata_pkg::ACC_WIDTH-1:0]  acc_out,
  output logic                           zero_out
);

  import ata_pkg::*;

  localparam logic [ACC_WIDTH-1:0] STEP_ANGLE = ATAN_TABLE[STEP];

  logic signed [W-1:0]     xs;
  logic signed [W-1:0]     ys;
  logic signed [W-1:0]     x_next;
  logic signed [W-1:0]     y_next;
  logic [ACC_WIDTH-1:0]    acc_next;

  always_comb begin
    xs = x_in >>> STEP;
    ys = y_in >>> STEP;
    if (y_in > 0) begin
      x_next   = x_in + ys;
      y_next   = y_in - xs;
      acc_next = acc_in + STEP_ANGLE;
    end else begin
      x_next   = x_in - ys;
      y_next   = y_in + xs;
      acc_next = acc_in - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_next;
      y_out    <= y_next;
      acc_out  <= acc_next;
      zero_out <= zero_in;
    end
  end

endmodule

@@ sv/accel_tilt_angles_unit.sv @@
// ----------------------------------------------------------------------------
// accel_tilt_angles_unit
// Tilt angles from three raw accelerometer samples: pitch, roll and angle
// from vertical, as signed binary angles (half scale = pi).
//
// A request on s_* carries x, y and z samples. The zero-g offset is removed,
// squares are summed, three roots come out of a digit-per-cell square root
// chain and three vectoring CORDIC chains form atan2 per angle.
// One result leaves on m_* per request. Throughput is one request per cycle
// unless the output stalls; a request runs through the delta, square and sum
// stages, the root chain, the quadrant fold and the CORDIC chain to m_*.
// cfg_* writes zero_g_offset; it is always ready and should only be written
// while no request is in flight.
// Reset empties the pipeline and the output register and loads the offset
// reset value. When m_tready is low the finished result holds in the output
// register; the chain keeps moving until its last stage also holds a result,
// then the whole chain stalls and s_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_tilt_angles_unit #(
  parameter int SAMPLE_BITS  = 12,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // sample_x, sample_y, sample_z, zero padded
  input  logic [(3*SAMPLE_BITS+7)/8*8-1:0]       s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pitch_angle, roll_angle, vertical_angle, zero padded
  output logic [(3*ANGLE_BITS+7)/8*8-1:0]        m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ata_pkg::CFG_WIDTH-1:0]          cfg_data
);

  import ata_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int AB    = ANGLE_BITS;
  localparam int CS    = CORDIC_STEPS;
  localparam int DW    = SB + 1;
  localparam int SQW   = 2 * SB;
  localparam int SUMW  = 2 * SB + 1;
  localparam int RB    = SB + 9;
  localparam int W     = SB + 12;
  localparam int NS    = 4 + RB + CS;
  localparam int IN_W  = (3 * SB + 7) / 8 * 8;
  localparam int OUT_W = (3 * AB + 7) / 8 * 8;

  localparam int LANE_PITCH    = 0;
  localparam int LANE_ROLL     = 1;
  localparam int LANE_VERTICAL = 2;

  logic [CFG_WIDTH-1:0] zero_g_offset;
  logic [NS-1:0]        vld;
  logic                 adv;
  logic                 load_out;

  // stage A: deltas
  logic signed [DW-1:0] d_a [3];
  // stage B: squares
  logic signed [DW-1:0] d_b  [3];
  logic [SQW-1:0]       sq_b [3];
  // stage C: sums, one per lane, with the lane's linear operand
  logic [SUMW-1:0]      sum_c  [3];
  logic signed [DW-1:0] pass_c [3];

  // root chain
  logic [2*RB-1:0]      rad_s  [3][RB+1];
  logic [RB+2:0]        rem_s  [3][RB+1];
  logic [RB-1:0]        root_s [3][RB+1];
  logic signed [DW-1:0] pass_s [3][RB+1];

  // CORDIC chain
  logic signed [W-1:0]   cx    [3][CS+1];
  logic signed [W-1:0]   cy    [3][CS+1];
  logic [ACC_WIDTH-1:0]  cacc  [3][CS+1];
  logic                  czero [3][CS+1];

  logic [AB-1:0]        angle [3];
  logic [OUT_W-1:0]     out_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_g_offset <= OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      zero_g_offset <= cfg_data;
    end
  end

  assign load_out = vld[NS-1] && (!m_tvalid || m_tready);
  assign adv      = !vld[NS-1] || !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], s_tvalid};
    end
  end

  // front stages
  logic [SB-1:0] off;
  logic [SB-1:0] smp [3];

  always_comb begin
    off    = SB'(zero_g_offset);
    smp[0] = s_tdata[SB-1:0];
    smp[1] = s_tdata[2*SB-1:SB];
    smp[2] = s_tdata[3*SB-1:2*SB];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_a[i]  <= $signed({1'b0, smp[i]}) - $signed({1'b0, off});
        d_b[i]  <= d_a[i];
        sq_b[i] <= $unsigned(SQW'(d_a[i]) * SQW'(d_a[i]));
      end
      sum_c[LANE_PITCH]     <= SUMW'(sq_b[1]) + SUMW'(sq_b[2]);
      sum_c[LANE_ROLL]      <= SUMW'(sq_b[0]) + SUMW'(sq_b[2]);
      sum_c[LANE_VERTICAL]  <= SUMW'(sq_b[0]) + SUMW'(sq_b[1]);
      pass_c[LANE_PITCH]    <= d_b[0];
      pass_c[LANE_ROLL]     <= d_b[1];
      pass_c[LANE_VERTICAL] <= d_b[2];
    end
  end

  genvar ln, k;
  generate
    for (ln = 0; ln < 3; ln++) begin : g_lane
      assign rad_s[ln][0]  = (2*RB)'({sum_c[ln], {(2*FRAC_BITS){1'b0}}});
      assign rem_s[ln][0]  = '0;
      assign root_s[ln][0] = '0;
      assign pass_s[ln][0] = pass_c[ln];

      for (k = 0; k < RB; k++) begin : g_root
        ata_sqrt_cell #(
          .RB   (RB),
          .PAIR (RB - 1 - k),
          .PW   (DW)
        ) u_cell (
          .clk      (clk),
          .en       (adv),
          .rad_in   (rad_s[ln][k]),
          .rem_in   (rem_s[ln][k]),
          .root_in  (root_s[ln][k]),
          .pass_in  (pass_s[ln][k]),
          .rad_out  (rad_s[ln][k+1]),
          .rem_out  (rem_s[ln][k+1]),
          .root_out (root_s[ln][k+1]),
          .pass_out (pass_s[ln][k+1])
        );
      end

      // quadrant fold ahead of the iterations
      logic signed [W-1:0] px;
      logic signed [W-1:0] py;

      always_comb begin
        if (ln == LANE_VERTICAL) begin
          px = W'(pass_s[ln][RB]) <<< FRAC_BITS;
          py = $signed(W'(root_s[ln][RB]));
        end else begin
          px = $signed(W'(root_s[ln][RB]));
          py = W'(pass_s[ln][RB]) <<< FRAC_BITS;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          czero[ln][0] <= (px == '0) && (py == '0);
          if (px < 0) begin
            if (py >= 0) begin
              cx[ln][0]   <= py;
              cy[ln][0]   <= -px;
              cacc[ln][0] <= QUARTER_TURN;
            end else begin
              cx[ln][0]   <= -py;
              cy[ln][0]   <= px;
              cacc[ln][0] <= -QUARTER_TURN;
            end
          end else begin
            cx[ln][0]   <= px;
            cy[ln][0]   <= py;
            cacc[ln][0] <= '0;
          end
        end
      end

      for (k = 0; k < CS; k++) begin : g_iter
        ata_cordic_cell #(
          .W    (W),
          .STEP (k)
        ) u_cell (
          .clk      (clk),
          .en       (adv),
          .x_in     (cx[ln][k]),
          .y_in     (cy[ln][k]),
          .acc_in   (cacc[ln][k]),
          .zero_in  (czero[ln][k]),
          .x_out    (cx[ln][k+1]),
          .y_out    (cy[ln][k+1]),
          .acc_out  (cacc[ln][k+1]),
          .zero_out (czero[ln][k+1])
        );
      end

      // round half up to the output width
      logic [ACC_WIDTH-1:0] rounded;

      always_comb begin
        rounded   = cacc[ln][CS] + (ACC_WIDTH'(1) << (ACC_WIDTH - 1 - AB));
        angle[ln] = czero[ln][CS] ? '0 : rounded[ACC_WIDTH-1 -: AB];
      end
    end
  endgenerate

  always_comb begin
    out_next = OUT_W'({angle[LANE_VERTICAL], angle[LANE_ROLL], angle[LANE_PITCH]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_next;
    end
  end

  // unused upper input bits are padding
  logic unused_pad;
  assign unused_pad = ^{1'b0, s_tdata[IN_W-1:3*SB]};

  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted request missing from first stage");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] && m_tvalid && !m_tready |=> vld[NS-1] && m_tvalid)
    else $error("result lost during stall");

  a_stall_blocks : assert property (@(posedge clk) disable iff (rst)
    vld[NS-1] && m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while chain is blocked");

endmodule
